// File: hdl/rgbc_color_vote_classifier_top_assert.svh
// Assertion macros used by the classifier top level.
// Every check is sampled on clk_i and held off while rst_ni is low.
`ifndef RGBC_COLOR_VOTE_CLASSIFIER_TOP_ASSERT_SVH
`define RGBC_COLOR_VOTE_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RGBC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RGBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rgbc_pkg.sv
package rgbc_pkg;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned CountW  = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Default depth of the internal queues
  localparam int unsigned QueueDepthDefault = 2;

  // Register reset values
  localparam logic [CountW-1:0]  WindowLengthRst      = 4'd10;
  localparam logic [CountW-1:0]  VoteThresholdRst     = 4'd8;
  localparam logic [SampleW-1:0] RedClearLimitRst     = 16'd75;
  localparam logic [SampleW-1:0] BlackClearLimitRst   = 16'd50;
  localparam logic [SampleW-1:0] BlackChannelLimitRst = 16'd20;

  // Color codes, in priority order
  typedef enum logic [1:0] {
    CODE_GREEN = 2'd0,
    CODE_RED   = 2'd1,
    CODE_BLACK = 2'd2,
    CODE_BLUE  = 2'd3
  } color_e;

  localparam int unsigned NumColors = 4;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_LENGTH       = 3'd0,
    CFG_VOTE_THRESHOLD      = 3'd1,
    CFG_RED_CLEAR_LIMIT     = 3'd2,
    CFG_BLACK_CLEAR_LIMIT   = 3'd3,
    CFG_BLACK_CHANNEL_LIMIT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CountW-1:0]  window_length;
    logic [CountW-1:0]  vote_threshold;
    logic [SampleW-1:0] red_clear_limit;
    logic [SampleW-1:0] black_clear_limit;
    logic [SampleW-1:0] black_channel_limit;
  } cfg_t;

  // Classified sample between front and back
  typedef struct packed {
    logic   unclass;
    color_e color;
  } item_t;

  // Result transaction
  typedef struct packed {
    color_e color;
    logic   forced;
  } res_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic cls_empty;
    logic res_full;
  } q_stat_t;

  // Back end handshake toward the queues
  typedef struct packed {
    logic cls_pop;
    logic res_push;
  } bk_ctrl_t;

endpackage

// File: hdl/rgbc_queue.sv
module rgbc_queue #(
  parameter int unsigned Width = 3,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: hdl/rgbc_front.sv
module rgbc_front
  import rgbc_pkg::*;
(
  input  logic [SampleW-1:0] red_i,
  input  logic [SampleW-1:0] green_i,
  input  logic [SampleW-1:0] blue_i,
  input  logic [SampleW-1:0] clear_i,
  input  cfg_t               cfg_i,
  output item_t              item_o
);

  logic is_green, is_red, is_black, is_blue;

  // Class tests
  assign is_green = (green_i > blue_i) && (green_i > red_i);
  assign is_red   = (red_i > green_i) && (red_i > blue_i) &&
                    (clear_i < cfg_i.red_clear_limit);
  assign is_black = (clear_i < cfg_i.black_clear_limit) &&
                    (red_i < cfg_i.black_channel_limit) &&
                    (green_i < cfg_i.black_channel_limit) &&
                    (blue_i < cfg_i.black_channel_limit);
  assign is_blue  = (blue_i > red_i) && (blue_i > green_i);

  // Priority pick: green, red, black, blue; a sample that fits none is black, marked unclassified
  always_comb begin
    item_o.unclass = 1'b0;
    if (is_green) begin
      item_o.color = CODE_GREEN;
    end else if (is_red) begin
      item_o.color = CODE_RED;
    end else if (is_black) begin
      item_o.color = CODE_BLACK;
    end else if (is_blue) begin
      item_o.color = CODE_BLUE;
    end else begin
      item_o.color   = CODE_BLACK;
      item_o.unclass = 1'b1;
    end
  end

endmodule

// File: hdl/rgbc_back.sv
module rgbc_back
  import rgbc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  q_stat_t  stat_i,
  input  item_t    item_i,
  output bk_ctrl_t ctrl_o,
  output res_t     res_o
);

  logic [CountW-1:0] samples_q, samples_d, samples_inc;
  logic [CountW-1:0] cnt_q   [NumColors];
  logic [CountW-1:0] cnt_d   [NumColors];
  logic [CountW-1:0] cnt_inc [NumColors];
  logic              go, win_end, found;
  color_e            vote;

  assign go          = !stat_i.cls_empty && !stat_i.res_full;
  assign samples_inc = samples_q + 1'b1;
  assign win_end     = !(samples_inc < cfg_i.window_length);

  // Per-class increment
  always_comb begin
    for (int i = 0; i < NumColors; i++) begin
      cnt_inc[i] = cnt_q[i] + CountW'(item_i.color == color_e'(i));
    end
  end

  // Vote over the updated counts, first class in priority order wins
  always_comb begin
    found = 1'b0;
    vote  = CODE_GREEN;
    for (int i = NumColors - 1; i >= 0; i--) begin
      if (cnt_inc[i] >= cfg_i.vote_threshold) begin
        found = 1'b1;
        vote  = color_e'(i);
      end
    end
  end

  // Counter update and result
  always_comb begin
    samples_d = samples_q;
    cnt_d     = cnt_q;
    ctrl_o.cls_pop  = go;
    ctrl_o.res_push = 1'b0;
    res_o.color     = vote;
    res_o.forced    = 1'b0;
    if (go) begin
      if (item_i.unclass) begin
        samples_d = '0;
        for (int i = 0; i < NumColors; i++) cnt_d[i] = '0;
        ctrl_o.res_push = 1'b1;
        res_o.color     = CODE_BLACK;
        res_o.forced    = 1'b1;
      end else if (win_end) begin
        samples_d = '0;
        for (int i = 0; i < NumColors; i++) cnt_d[i] = '0;
        ctrl_o.res_push = found;
      end else begin
        samples_d = samples_inc;
        cnt_d     = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= '0;
      for (int i = 0; i < NumColors; i++) cnt_q[i] <= '0;
    end else begin
      samples_q <= samples_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

// File: hdl/rgbc_color_vote_classifier_top.sv
// Flow: a sample accepted into the class queue is counted by the back end once the result
//   queue has room; its result (if any) goes into the result queue, where the consumer pops it.
// Throughput: one sample per cycle while the result queue has room, set by the count-and-vote step.
// Reset (rst_ni low, asynchronous): counters and both queues empty, registers at defaults.
module rgbc_color_vote_classifier_top
  import rgbc_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Sample side
  input  logic                push,
  output logic                full,
  input  logic [SampleW-1:0]  red_raw_i,
  input  logic [SampleW-1:0]  green_raw_i,
  input  logic [SampleW-1:0]  blue_raw_i,
  input  logic [SampleW-1:0]  clear_raw_i,
  // Result side
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          color_code_o,
  output logic                forced_black_o,
  // Register writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

`include "rgbc_color_vote_classifier_top_assert.svh"

  cfg_t     cfg_q;
  item_t    fr_item, cls_item;
  res_t     bk_res, out_res;
  q_stat_t  q_stat;
  bk_ctrl_t bk_ctrl;
  logic     cls_full, cls_empty;
  logic     res_full, res_empty;
  logic [$bits(item_t)-1:0] cls_rdata;
  logic [$bits(res_t)-1:0]  res_rdata;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length       <= WindowLengthRst;
      cfg_q.vote_threshold      <= VoteThresholdRst;
      cfg_q.red_clear_limit     <= RedClearLimitRst;
      cfg_q.black_clear_limit   <= BlackClearLimitRst;
      cfg_q.black_channel_limit <= BlackChannelLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_LENGTH:       cfg_q.window_length       <= cfg_wdata_i[CountW-1:0];
        CFG_VOTE_THRESHOLD:      cfg_q.vote_threshold      <= cfg_wdata_i[CountW-1:0];
        CFG_RED_CLEAR_LIMIT:     cfg_q.red_clear_limit     <= cfg_wdata_i[SampleW-1:0];
        CFG_BLACK_CLEAR_LIMIT:   cfg_q.black_clear_limit   <= cfg_wdata_i[SampleW-1:0];
        CFG_BLACK_CHANNEL_LIMIT: cfg_q.black_channel_limit <= cfg_wdata_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  // Front: classify on the way in
  rgbc_front u_front (
    .red_i   (red_raw_i),
    .green_i (green_raw_i),
    .blue_i  (blue_raw_i),
    .clear_i (clear_raw_i),
    .cfg_i   (cfg_q),
    .item_o  (fr_item)
  );

  // Class queue between front and back
  rgbc_queue #(
    .Width ($bits(item_t)),
    .Depth (QueueDepth)
  ) u_cls_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (fr_item),
    .full_o  (cls_full),
    .pop_i   (bk_ctrl.cls_pop),
    .rdata_o (cls_rdata),
    .empty_o (cls_empty)
  );

  assign full     = cls_full;
  assign cls_item = item_t'(cls_rdata);

  // Back: window counters and vote
  assign q_stat.cls_empty = cls_empty;
  assign q_stat.res_full  = res_full;

  rgbc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .stat_i (q_stat),
    .item_i (cls_item),
    .ctrl_o (bk_ctrl),
    .res_o  (bk_res)
  );

  // Result queue toward the consumer
  rgbc_queue #(
    .Width ($bits(res_t)),
    .Depth (QueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_ctrl.res_push),
    .wdata_i (bk_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (res_empty)
  );

  assign out_res        = res_t'(res_rdata);
  assign empty          = res_empty;
  assign color_code_o   = out_res.color;
  assign forced_black_o = out_res.forced;

  // Checks
  `RGBC_ASSERT_IMPL(a_unclass_reports, bk_ctrl.cls_pop && cls_item.unclass, bk_ctrl.res_push, "unclassifiable sample gave no result")
  `RGBC_ASSERT_IMPL(a_result_needs_sample, bk_ctrl.res_push, bk_ctrl.cls_pop && !res_full, "result pushed without a sample")
  `RGBC_ASSERT_NEXT(a_accept_queues, push && !full, !cls_empty, "accepted sample missing from class queue")

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbc_pkg::*;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandPhases    = 13;
  localparam int unsigned ItemsPerPhase = 80;
  localparam int unsigned BurstItems    = 40;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned MaxChannel    = 2**SampleW - 1;

  typedef struct packed {
    logic [SampleW-1:0] red;
    logic [SampleW-1:0] green;
    logic [SampleW-1:0] blue;
    logic [SampleW-1:0] clear;
  } sample_t;

  // What kind of sample the generator should aim for
  typedef enum int {
    MK_GREEN,
    MK_RED,
    MK_BLACK,
    MK_BLUE,
    MK_UNCLASS,
    MK_NOISE
  } sample_kind_e;

  // Clock, reset and DUT inputs, all known from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                push        = 1'b0;
  logic [SampleW-1:0]  red_raw_i   = '0;
  logic [SampleW-1:0]  green_raw_i = '0;
  logic [SampleW-1:0]  blue_raw_i  = '0;
  logic [SampleW-1:0]  clear_raw_i = '0;
  logic                pop         = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  logic                full;
  logic                empty;
  logic [1:0]          color_code_o;
  logic                forced_black_o;

  // Shadow registers and vote counters
  cfg_t cfg_model = '{
    window_length:       WindowLengthRst,
    vote_threshold:      VoteThresholdRst,
    red_clear_limit:     RedClearLimitRst,
    black_clear_limit:   BlackClearLimitRst,
    black_channel_limit: BlackChannelLimitRst
  };
  logic [CountW-1:0] win_fill    = '0;
  logic [CountW-1:0] green_votes = '0;
  logic [CountW-1:0] red_votes   = '0;
  logic [CountW-1:0] black_votes = '0;
  logic [CountW-1:0] blue_votes  = '0;

  res_t expected_colors[$];

  int unsigned fail_count       = 0;
  int unsigned stall_cycles     = 0;
  int unsigned sink_hold_cycles = 0;
  bit          tx_gaps_on       = 1'b1;
  bit          rx_stalls_on     = 1'b1;

  rgbc_color_vote_classifier_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .red_raw_i      (red_raw_i),
    .green_raw_i    (green_raw_i),
    .blue_raw_i     (blue_raw_i),
    .clear_raw_i    (clear_raw_i),
    .empty          (empty),
    .pop            (pop),
    .color_code_o   (color_code_o),
    .forced_black_o (forced_black_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Watchdog: cycles in a row with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void clear_votes();
    win_fill    = '0;
    green_votes = '0;
    red_votes   = '0;
    black_votes = '0;
    blue_votes  = '0;
  endfunction

  // Sort one sample, count it and queue the window decision if one falls due
  function automatic void classify_and_vote(input sample_t s);
    color_e pick;
    logic   found;
    found = 1'b1;
    pick  = CODE_GREEN;
    if (s.green > s.blue && s.green > s.red) begin
      green_votes++;
    end else if (s.red > s.green && s.red > s.blue &&
                 s.clear < cfg_model.red_clear_limit) begin
      red_votes++;
    end else if (s.clear < cfg_model.black_clear_limit &&
                 s.red < cfg_model.black_channel_limit &&
                 s.green < cfg_model.black_channel_limit &&
                 s.blue < cfg_model.black_channel_limit) begin
      black_votes++;
    end else if (s.blue > s.red && s.blue > s.green) begin
      blue_votes++;
    end else begin
      // fits no class: black is forced and the window restarts
      clear_votes();
      expected_colors.push_back('{color: CODE_BLACK, forced: 1'b1});
      return;
    end

    win_fill++;
    if (win_fill < cfg_model.window_length) return;

    if (green_votes >= cfg_model.vote_threshold)      pick = CODE_GREEN;
    else if (red_votes >= cfg_model.vote_threshold)   pick = CODE_RED;
    else if (black_votes >= cfg_model.vote_threshold) pick = CODE_BLACK;
    else if (blue_votes >= cfg_model.vote_threshold)  pick = CODE_BLUE;
    else found = 1'b0;

    clear_votes();
    if (found) expected_colors.push_back('{color: pick, forced: 1'b0});
  endfunction

  // Build a sample aimed at one class under the current limits
  function automatic sample_t make_sample(input sample_kind_e kind);
    sample_t s;
    int unsigned v;
    s.red   = SampleW'($urandom);
    s.green = SampleW'($urandom);
    s.blue  = SampleW'($urandom);
    s.clear = SampleW'($urandom);
    case (kind)
      MK_GREEN: begin
        s.green = SampleW'($urandom_range(MaxChannel, 1));
        s.red   = SampleW'($urandom_range(s.green - 1, 0));
        s.blue  = SampleW'($urandom_range(s.green - 1, 0));
      end
      MK_RED: begin
        if (cfg_model.red_clear_limit != 0) begin
          s.red   = SampleW'($urandom_range(MaxChannel, 1));
          s.green = SampleW'($urandom_range(s.red - 1, 0));
          s.blue  = SampleW'($urandom_range(s.red - 1, 0));
          s.clear = SampleW'($urandom_range(cfg_model.red_clear_limit - 1, 0));
        end
      end
      MK_BLACK: begin
        // red equal to green keeps it out of the green and red classes
        if (cfg_model.black_clear_limit != 0 && cfg_model.black_channel_limit != 0) begin
          v       = $urandom_range(cfg_model.black_channel_limit - 1, 0);
          s.red   = SampleW'(v);
          s.green = SampleW'(v);
          s.blue  = SampleW'($urandom_range(v, 0));
          s.clear = SampleW'($urandom_range(cfg_model.black_clear_limit - 1, 0));
        end
      end
      MK_BLUE: begin
        s.blue  = SampleW'($urandom_range(MaxChannel, 1));
        s.red   = SampleW'($urandom_range(s.blue - 1, 0));
        s.green = SampleW'($urandom_range(s.blue - 1, 0));
      end
      MK_UNCLASS: begin
        v       = $urandom_range(MaxChannel, cfg_model.black_channel_limit);
        s.red   = SampleW'(v);
        s.green = SampleW'(v);
        s.blue  = SampleW'(v);
      end
      default: ;
    endcase
    return s;
  endfunction

  // Offer one sample; returns at the edge that accepts it, push left high
  task automatic offer_sample(input sample_t s);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(9, 0) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    red_raw_i   <= s.red;
    green_raw_i <= s.green;
    blue_raw_i  <= s.blue;
    clear_raw_i <= s.clear;
    do @(posedge clk_i); while (full);
    classify_and_vote(s);
  endtask

  // Stop offering, wait for every expected result, then let the pipe settle
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all registers, then junk to the unused indexes
  task automatic write_config(input cfg_t c);
    logic [CfgDataW-1:0] word;
    cfg_we_i  <= 1'b1;
    word = CfgDataW'($urandom);
    word[CountW-1:0] = c.window_length;
    cfg_idx_i   <= CFG_WINDOW_LENGTH;
    cfg_wdata_i <= word;
    @(posedge clk_i);
    word = CfgDataW'($urandom);
    word[CountW-1:0] = c.vote_threshold;
    cfg_idx_i   <= CFG_VOTE_THRESHOLD;
    cfg_wdata_i <= word;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RED_CLEAR_LIMIT;
    cfg_wdata_i <= c.red_clear_limit;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BLACK_CLEAR_LIMIT;
    cfg_wdata_i <= c.black_clear_limit;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BLACK_CHANNEL_LIMIT;
    cfg_wdata_i <= c.black_channel_limit;
    @(posedge clk_i);
    for (int i = int'(CFG_BLACK_CHANNEL_LIMIT) + 1; i < 2**CfgIdxW; i++) begin
      cfg_idx_i   <= CfgIdxW'(i);
      cfg_wdata_i <= CfgDataW'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    cfg_model = c;
  endtask

  // Result side: compare the popped result with the oldest expectation (the sink stalls at random)
  task automatic check_result();
    res_t want;
    if (expected_colors.size() == 0) begin
      $error("result with nothing expected: color_code %0d forced_black %0b",
             color_code_o, forced_black_o);
      fail_count++;
    end else begin
      want = expected_colors.pop_front();
      if (color_code_o !== want.color) begin
        $error("color_code: expected %0d, got %0d", want.color, color_code_o);
        fail_count++;
      end
      if (forced_black_o !== want.forced) begin
        $error("forced_black: expected %0b, got %0b", want.forced, forced_black_o);
        fail_count++;
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_stalls_on ? $urandom_range(9, 0) : 0;
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      check_result();
    end
  end

  // Reset values: extremes of the fields and one full default window won by green
  task automatic test_reset_defaults();
    sample_t s;
    offer_sample('0);
    s = '{red: '0, green: '1, blue: '0, clear: '1};
    offer_sample(s);
    repeat (7) offer_sample(make_sample(MK_GREEN));
    // red with clear one below its limit
    s = '{red: '1, green: '0, blue: '0, clear: SampleW'(RedClearLimitRst - 1)};
    offer_sample(s);
    offer_sample('1);
    wait_idle();
  endtask

  // Zero window and threshold, then one-sample windows through every class
  task automatic test_corner_settings();
    cfg_t c;
    sample_t s;
    c = '{window_length: '0, vote_threshold: '0, red_clear_limit: RedClearLimitRst,
          black_clear_limit: BlackClearLimitRst, black_channel_limit: BlackChannelLimitRst};
    write_config(c);
    offer_sample(make_sample(MK_BLUE));
    wait_idle();

    c.window_length  = CountW'(1);
    c.vote_threshold = CountW'(1);
    write_config(c);
    offer_sample(make_sample(MK_GREEN));
    offer_sample(make_sample(MK_RED));
    offer_sample(make_sample(MK_BLACK));
    offer_sample(make_sample(MK_BLUE));
    offer_sample(make_sample(MK_UNCLASS));
    // red at clear equal to its limit is no longer red
    s = '{red: '1, green: '0, blue: '0, clear: RedClearLimitRst};
    offer_sample(s);
    wait_idle();
  endtask

  // Phases of random settings, each fed with windows dominated by one class
  task automatic test_random_windows();
    cfg_t c;
    sample_kind_e major;
    int unsigned sent;
    int unsigned roll;
    int unsigned span;
    for (int ph = 0; ph < RandPhases; ph++) begin
      c.window_length       = CountW'($urandom_range(15, 0));
      span                  = (c.window_length == 0) ? 1 : c.window_length;
      c.vote_threshold      = CountW'(($urandom_range(9, 0) == 0) ? $urandom_range(15, 0)
                                                                  : $urandom_range(span, 0));
      c.red_clear_limit     = SampleW'($urandom_range(1, 0) ? $urandom
                                                            : $urandom_range(255, 0));
      c.black_clear_limit   = SampleW'($urandom_range(1, 0) ? $urandom
                                                            : $urandom_range(255, 0));
      c.black_channel_limit = SampleW'($urandom_range(1, 0) ? $urandom
                                                            : $urandom_range(255, 0));
      if (ph == 0) c = '{window_length: '1, vote_threshold: '1, red_clear_limit: '1,
                         black_clear_limit: '1, black_channel_limit: '1};
      if (ph == 1) c = '{window_length: '1, vote_threshold: CountW'(1), red_clear_limit: '0,
                         black_clear_limit: '0, black_channel_limit: '0};
      if (ph == 2) begin
        c.window_length  = '0;
        c.vote_threshold = '0;
      end
      write_config(c);
      span = (c.window_length == 0) ? 1 : c.window_length;

      // every fourth phase runs back to back on both sides
      tx_gaps_on   = (ph % 4 != 3);
      rx_stalls_on = (ph % 4 != 3);

      sent = 0;
      while (sent < ItemsPerPhase) begin
        major = sample_kind_e'($urandom_range(int'(MK_BLUE), int'(MK_GREEN)));
        for (int k = 0; k < span; k++) begin
          roll = $urandom_range(99, 0);
          if (roll < 4)
            offer_sample(make_sample(MK_UNCLASS));
          else if (roll < 10)
            offer_sample(make_sample(MK_NOISE));
          else if (roll < 20)
            offer_sample(make_sample(
                sample_kind_e'($urandom_range(int'(MK_BLUE), int'(MK_GREEN)))));
          else
            offer_sample(make_sample(major));
          sent++;
        end
      end
      wait_idle();
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Result side held off for a long stretch while samples keep coming
  task automatic test_output_backpressure();
    cfg_t c;
    c = '{window_length: CountW'(1), vote_threshold: CountW'(1), red_clear_limit: '1,
          black_clear_limit: '1, black_channel_limit: '1};
    write_config(c);
    tx_gaps_on       = 1'b0;
    sink_hold_cycles = LongHold;
    repeat (BurstItems)
      offer_sample(make_sample(sample_kind_e'($urandom_range(int'(MK_NOISE),
                                                             int'(MK_GREEN)))));
    wait_idle();
    tx_gaps_on = 1'b1;
  endtask

  initial begin : stimulus
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_corner_settings();
    test_random_windows();
    test_output_backpressure();

    wait_idle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rgbc_pkg.sv
hdl/rgbc_queue.sv
hdl/rgbc_front.sv
hdl/rgbc_back.sv
hdl/rgbc_color_vote_classifier_top.sv
bench/tb.sv
